// ===== rtl/cln_pkg.sv =====
package cln_pkg;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] byte_value;
	} req_item_t;

	typedef struct packed {
		logic [3:0] data_nibble;
		logic       reg_select;
		logic       enable_level;
		logic       busy_res;
		logic       rejected;
	} res_item_t;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_CMD  = 2'd1,
		OP_DATA = 2'd2,
		OP_INIT = 2'd3
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] byte_value;
	} queue_item_t;

	// Front-to-back queue head handshake
	typedef struct packed {
		logic        valid;
		queue_item_t item;
	} queue_head_t;

	typedef enum logic [4:0] {
		PH_IDLE     = 5'b00001,
		PH_WAIT     = 5'b00010,
		PH_HI_PULSE = 5'b00100,
		PH_HI_GAP   = 5'b01000,
		PH_LO_PULSE = 5'b10000
	} phase_t;

	localparam int unsigned CFG_WIDTH = 16;
	localparam int unsigned ADDR_WIDTH = 4;

	typedef enum logic [1:0] {
		REG_PULSE   = 2'd0,
		REG_POWERUP = 2'd1,
		REG_GAP     = 2'd2
	} reg_index_t;

	localparam logic [CFG_WIDTH-1:0] PULSE_RST   = 16'd10;
	localparam logic [CFG_WIDTH-1:0] POWERUP_RST = 16'd20;
	localparam logic [CFG_WIDTH-1:0] GAP_RST     = 16'd1;

	localparam logic [2:0] INIT_FIRST = 3'd1;
	localparam logic [2:0] INIT_LAST  = 3'd5;

	function automatic logic [7:0] init_cmd(input logic [2:0] step);
		logic [7:0] cmd;
		case (step)
			3'd1: cmd = 8'h33;
			3'd2: cmd = 8'h32;
			3'd3: cmd = 8'h0C;
			3'd4: cmd = 8'h01;
			3'd5: cmd = 8'h80;
			default: cmd = 8'h00;
		endcase
		return cmd;
	endfunction

endpackage

// ===== rtl/char_lcd_nibble_writer.sv =====
// Character LCD writer for a 4-bit HD44780-style bus.
//
// Request channel (req_valid/req_ready/req): each item is a tick, a command
// byte, a data byte or an init request. Only ticks advance time; every item
// produces exactly one result item on the result channel
// (res_valid/res_ready/res) with the pin levels after that item, the busy
// flag and a reject flag for requests that arrived while busy.
//
// Throughput: one item per cycle while the result channel does not stall.
// Each accepted request is written into the 2-entry front queue; the
// execute stage pops it from there and loads the result register, which
// raises res_valid, at the edge that pops it.
// When the receiver stalls, the result register holds; the queue absorbs up
// to two more items, then req_ready drops.
//
// Reset (arst_n low): sequencer idle, pins low, queue and result empty,
// registers back to pulse 10, power-up 20, init gap 1 ticks.
// Registers via APB at 0x0 pulse_ticks, 0x4 powerup_ticks, 0x8
// init_gap_ticks (16 bits each); write only while the block is idle.
module char_lcd_nibble_writer import cln_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_item_t             req,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_item_t             res,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_WIDTH-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic [CFG_WIDTH-1:0] pulse_ticks_q;
	logic [CFG_WIDTH-1:0] powerup_ticks_q;
	logic [CFG_WIDTH-1:0] init_gap_ticks_q;
	logic                 cfg_wr;
	logic [1:0]           reg_idx;
	queue_head_t          head;
	logic                 pop;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_ticks_q    <= PULSE_RST;
			powerup_ticks_q  <= POWERUP_RST;
			init_gap_ticks_q <= GAP_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_PULSE:   pulse_ticks_q    <= pwdata[CFG_WIDTH-1:0];
				REG_POWERUP: powerup_ticks_q  <= pwdata[CFG_WIDTH-1:0];
				REG_GAP:     init_gap_ticks_q <= pwdata[CFG_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PULSE:   prdata = {16'd0, pulse_ticks_q};
			REG_POWERUP: prdata = {16'd0, powerup_ticks_q};
			REG_GAP:     prdata = {16'd0, init_gap_ticks_q};
			default:     prdata = 32'd0;
		endcase
	end

	cln_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.head      (head),
		.pop       (pop)
	);

	cln_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.pop            (pop),
		.pulse_ticks    (pulse_ticks_q),
		.powerup_ticks  (powerup_ticks_q),
		.init_gap_ticks (init_gap_ticks_q),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res            (res)
	);

endmodule

// ===== rtl/cln_front.sv =====
module cln_front import cln_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_item_t   req,
	output queue_head_t head,
	input  logic        pop
);

	queue_item_t mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	queue_item_t enq;

	assign req_ready = (count_q != 2'd2);
	assign push      = req_valid && req_ready;

	always_comb begin
		enq.byte_value = req.byte_value;
		case (req.opcode)
			OP_TICK: enq.kind = OP_TICK;
			OP_CMD:  enq.kind = OP_CMD;
			OP_DATA: enq.kind = OP_DATA;
			default: enq.kind = OP_INIT;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= enq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head.valid = (count_q != 2'd0);
	assign head.item  = mem_q[rd_ptr_q];

endmodule

// ===== rtl/cln_back.sv =====
module cln_back import cln_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  queue_head_t          head,
	output logic                 pop,
	input  logic [CFG_WIDTH-1:0] pulse_ticks,
	input  logic [CFG_WIDTH-1:0] powerup_ticks,
	input  logic [CFG_WIDTH-1:0] init_gap_ticks,
	output logic                 res_valid,
	input  logic                 res_ready,
	output res_item_t            res
);

	localparam logic [32:0] CAP = (33'd1 << COUNT_WIDTH) - 33'd1;

	function automatic logic [COUNT_WIDTH-1:0] load_count(input logic [CFG_WIDTH-1:0] v);
		logic [32:0] wide;
		wide = {{(33-CFG_WIDTH){1'b0}}, v};
		return (wide > CAP) ? CAP[COUNT_WIDTH-1:0] : wide[COUNT_WIDTH-1:0];
	endfunction

	phase_t                 phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] countdown_q, countdown_d, cd_dec;
	logic [7:0]             held_byte_q, held_byte_d;
	logic [2:0]             init_step_q, init_step_d;
	logic [3:0]             pin_data_q, pin_data_d;
	logic                   pin_rs_q, pin_rs_d;
	logic                   pin_enable_q, pin_enable_d;
	logic                   rej;
	logic                   res_valid_q;
	res_item_t              res_q;
	logic [COUNT_WIDTH-1:0] pulse_load;
	logic [7:0]             start_val;
	logic                   start_rs;
	logic                   do_start;

	assign pop        = head.valid && (!res_valid_q || res_ready);
	assign pulse_load = load_count((pulse_ticks == '0) ? CFG_WIDTH'(1) : pulse_ticks);
	assign cd_dec     = (countdown_q != '0) ? countdown_q - COUNT_WIDTH'(1) : countdown_q;

	always_comb begin
		phase_d      = phase_q;
		countdown_d  = countdown_q;
		held_byte_d  = held_byte_q;
		init_step_d  = init_step_q;
		pin_data_d   = pin_data_q;
		pin_rs_d     = pin_rs_q;
		pin_enable_d = pin_enable_q;
		rej          = 1'b0;
		do_start     = 1'b0;
		start_val    = head.item.byte_value;
		start_rs     = (head.item.kind == OP_DATA);

		if (head.item.kind == OP_TICK) begin
			case (phase_q)
				PH_WAIT: begin
					if (countdown_q != '0) begin
						countdown_d = countdown_q - COUNT_WIDTH'(1);
					end else if (init_step_q >= INIT_FIRST && init_step_q <= INIT_LAST) begin
						do_start  = 1'b1;
						start_val = init_cmd(init_step_q);
						start_rs  = 1'b0;
					end else begin
						init_step_d = '0;
						phase_d     = PH_IDLE;
					end
				end
				PH_HI_PULSE, PH_LO_PULSE: begin
					countdown_d = cd_dec;
					if (cd_dec == '0) begin
						pin_enable_d = 1'b0;
						if (phase_q == PH_HI_PULSE) begin
							phase_d = PH_HI_GAP;
						end else if (init_step_q == '0) begin
							phase_d = PH_IDLE;
						end else if (init_step_q >= INIT_LAST) begin
							init_step_d = '0;
							phase_d     = PH_IDLE;
						end else begin
							// only the first init command is followed by a gap
							countdown_d = (init_step_q == INIT_FIRST) ?
								load_count(init_gap_ticks) : '0;
							init_step_d = init_step_q + 3'd1;
							phase_d     = PH_WAIT;
						end
					end
				end
				PH_HI_GAP: begin
					pin_data_d   = held_byte_q[3:0];
					pin_enable_d = 1'b1;
					countdown_d  = pulse_load;
					phase_d      = PH_LO_PULSE;
				end
				default: phase_d = PH_IDLE;
			endcase
		end else if (phase_q != PH_IDLE) begin
			rej = 1'b1;
		end else if (head.item.kind == OP_INIT) begin
			init_step_d = INIT_FIRST;
			countdown_d = load_count(powerup_ticks);
			phase_d     = PH_WAIT;
		end else begin
			do_start = 1'b1;
		end

		if (do_start) begin
			held_byte_d  = start_val;
			pin_rs_d     = start_rs;
			pin_data_d   = start_val[7:4];
			pin_enable_d = 1'b1;
			countdown_d  = pulse_load;
			phase_d      = PH_HI_PULSE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			countdown_q  <= '0;
			held_byte_q  <= '0;
			init_step_q  <= '0;
			pin_data_q   <= '0;
			pin_rs_q     <= 1'b0;
			pin_enable_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				phase_q      <= phase_d;
				countdown_q  <= countdown_d;
				held_byte_q  <= held_byte_d;
				init_step_q  <= init_step_d;
				pin_data_q   <= pin_data_d;
				pin_rs_q     <= pin_rs_d;
				pin_enable_q <= pin_enable_d;
				res_valid_q  <= 1'b1;
			end else if (res_ready) begin
				res_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.data_nibble  <= pin_data_d;
			res_q.reg_select   <= pin_rs_d;
			res_q.enable_level <= pin_enable_d;
			res_q.busy_res     <= (phase_d != PH_IDLE);
			res_q.rejected     <= rej;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== rtl/cln_checker.sv =====
module cln_checker import cln_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      res_valid,
	input logic      res_ready,
	input res_item_t res
);

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// a rejected request leaves the sequencer busy
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.rejected |-> res.busy_res)
		else $error("reject reported while idle");

	// enable strobe only inside a transfer
	a_en_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.enable_level |-> res.busy_res)
		else $error("enable high while idle");

	// idle results keep the strobe low
	a_idle_en: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.busy_res |-> !res.enable_level && !res.rejected)
		else $error("idle result with strobe or reject");

endmodule

bind char_lcd_nibble_writer cln_checker u_cln_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);
